// ===== rtl/kprt_pkg.sv =====
// ----------------------------------------------------------------------------
// kprt_pkg
// Shared constants, types and the key code mapping for the key press/release
// timeout core.
// ----------------------------------------------------------------------------
package kprt_pkg;

  localparam int NUM_CODES = 256;
  localparam int CODE_W    = $clog2(NUM_CODES);
  localparam int TIMER_W   = 3;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(4);

  localparam logic [7:0] CHAR_W = 8'h77;
  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_D = 8'h64;

  localparam logic [7:0] KEY_UP    = 8'had;
  localparam logic [7:0] KEY_DOWN  = 8'haf;
  localparam logic [7:0] KEY_LEFT  = 8'hac;
  localparam logic [7:0] KEY_RIGHT = 8'hae;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // control from the sequencer to the timer ring
  typedef struct packed {
    logic               shift;
    logic [TIMER_W-1:0] head;
  } ring_ctrl_t;

  function automatic logic [7:0] map_code(input logic [7:0] code);
    logic [7:0] key;
    unique case (code)
      CHAR_W:  key = KEY_UP;
      CHAR_S:  key = KEY_DOWN;
      CHAR_A:  key = KEY_LEFT;
      CHAR_D:  key = KEY_RIGHT;
      default: key = code;
    endcase
    return key;
  endfunction

endpackage

// ===== rtl/kprt_cell.sv =====
// ----------------------------------------------------------------------------
// kprt_cell
// One hold timer of the rotating timer ring; takes its neighbor's value on
// every shift.
// ----------------------------------------------------------------------------
module kprt_cell import kprt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic [TIMER_W-1:0] timer_i,
  output logic [TIMER_W-1:0] timer_o
);

  logic [TIMER_W-1:0] timer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
    end else if (shift_i) begin
      timer_q <= timer_i;
    end
  end

  assign timer_o = timer_q;

endmodule

// ===== rtl/kprt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kprt_ctrl
// Walk sequencer: rotates the timer ring once per item, updates the timer at
// the ring head, and holds the result register.
// ----------------------------------------------------------------------------
module kprt_ctrl import kprt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [7:0]         char_code_i,
  input  logic [TIMER_W-1:0] timeout_i,
  input  logic [TIMER_W-1:0] head_i,
  output ring_ctrl_t         ring_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_press_o,
  output logic [7:0]         game_key_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  localparam logic [CODE_W-1:0] LAST_POS = CODE_W'(NUM_CODES - 1);

  state_e             state_q;
  logic [CODE_W-1:0]  pos_q;
  logic               kind_q;
  logic [CODE_W-1:0]  code_q;
  logic               stop_q;
  logic               pend_q;
  logic               pend_press_q;
  logic [CODE_W-1:0]  pend_key_q;
  logic               out_valid_q;
  logic               is_press_q;
  logic [7:0]         game_key_q;

  logic               in_xfer;
  logic               out_free;
  logic               out_load;
  logic               hit;
  logic [TIMER_W-1:0] load;
  logic [TIMER_W-1:0] head_new;
  logic               set_pend;
  logic               set_press;
  logic               code_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign code_ok    = int'(char_code_i) < NUM_CODES;

  assign hit  = (pos_q == code_q);
  assign load = (timeout_i == '0) ? TIMER_W'(1) : timeout_i;

  always_comb begin
    head_new  = head_i;
    set_pend  = 1'b0;
    set_press = 1'b0;
    if (kind_q == KIND_CHAR) begin
      if (hit) begin
        head_new = load;
        if (head_i == '0) begin
          set_pend  = 1'b1;
          set_press = 1'b1;
        end
      end
    end else if (!stop_q && head_i != '0) begin
      head_new = head_i - TIMER_W'(1);
      if (head_i == TIMER_W'(1)) begin
        set_pend = 1'b1;
      end
    end
  end

  assign out_load = out_free &&
                    ((state_q == ST_FLUSH) ||
                     (state_q == ST_WALK && pos_q == LAST_POS && (set_pend || pend_q)));

  assign ring_o.shift = (state_q == ST_WALK);
  assign ring_o.head  = head_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      kind_q       <= KIND_CHAR;
      code_q       <= '0;
      stop_q       <= 1'b0;
      pend_q       <= 1'b0;
      pend_press_q <= 1'b0;
      pend_key_q   <= '0;
      out_valid_q  <= 1'b0;
      is_press_q   <= 1'b0;
      game_key_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer && (kind_i == KIND_TICK || code_ok)) begin
            state_q <= ST_WALK;
            pos_q   <= '0;
            kind_q  <= kind_i;
            code_q  <= char_code_i[CODE_W-1:0];
            stop_q  <= 1'b0;
            pend_q  <= 1'b0;
          end
        end
        ST_WALK: begin
          if (set_pend) begin
            pend_q       <= 1'b1;
            pend_press_q <= set_press;
            pend_key_q   <= pos_q;
            stop_q       <= 1'b1;
          end
          if (pos_q == LAST_POS) begin
            pos_q <= '0;
            if (set_pend || pend_q) begin
              if (out_free) begin
                is_press_q  <= set_pend ? set_press : pend_press_q;
                game_key_q  <= map_code(8'(set_pend ? pos_q : pend_key_q));
                state_q     <= ST_IDLE;
              end else begin
                state_q <= ST_FLUSH;
              end
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            pos_q <= pos_q + CODE_W'(1);
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            is_press_q  <= pend_press_q;
            game_key_q  <= map_code(8'(pend_key_q));
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_press_o  = is_press_q;
  assign game_key_o  = game_key_q;

endmodule

// ===== rtl/key_press_release_timeout_core.sv =====
// ----------------------------------------------------------------------------
// key_press_release_timeout_core
// Key press/release detector with one hold timer per character code, kept in
// a rotating ring of timer cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_ready_o    kind_i, char_code_i
//  out       output     out_valid_o / out_ready_i  is_press_o, game_key_o
//  cfg       input      cfg_valid_i / cfg_ready_o  release_timeout_i
//
//  Every item except an out-of-range code rotates the ring one full turn:
//  all NUM_CODES timers (256) pass the ring head, one timer per cycle.
//  Input is taken one item at a time; in_ready_o returns once the walk
//  and any wait to load its result are over. A result waits in the
//  output register; a finished walk stalls only if the previous result
//  is still not taken.
//  Reset clears all timers at once and sets the timeout to 4.
// ----------------------------------------------------------------------------
module key_press_release_timeout_core import kprt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [7:0]          char_code_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                is_press_o,
  output logic [7:0]          game_key_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TIMER_W-1:0]  release_timeout_i
);

  logic [TIMER_W-1:0] timeout_q;
  logic [TIMER_W-1:0] timer_w [NUM_CODES];
  ring_ctrl_t         ring;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= release_timeout_i;
    end
  end

  for (genvar i = 0; i < NUM_CODES; i++) begin : g_cell
    if (i == NUM_CODES - 1) begin : g_tail
      kprt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring.shift),
        .timer_i (ring.head),
        .timer_o (timer_w[i])
      );
    end else begin : g_body
      kprt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring.shift),
        .timer_i (timer_w[i+1]),
        .timer_o (timer_w[i])
      );
    end
  end

  kprt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .timeout_i   (timeout_q),
    .head_i      (timer_w[0]),
    .ring_o      (ring),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_press_o  (is_press_o),
    .game_key_o  (game_key_o)
  );

endmodule
